@@ rtl/k_way_sorted_merge_defines.svh @@
// Assertion macros shared by the merge RTL.
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

// Concurrent check on a given clock, masked while reset is asserted.
`define KWM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same check on the block clock and reset.
`define KWM_ASSERT_CLK(lbl, prop, msg) \
    `KWM_ASSERT(lbl, aclk, aresetn, prop, msg)

`endif

@@ rtl/kwm_pkg.sv @@
package kwm_pkg;

    localparam int CFG_BITS = 5;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic valid;
        logic present;
    } cmp_ctrl_t;

endpackage

@@ rtl/kwm_min_track.sv @@
module kwm_min_track #(
    parameter int IDX_BITS = 4,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kwm_pkg::cmp_ctrl_t    ctrl,
    input  logic [IDX_BITS-1:0]   cand_idx,
    input  logic [VALUE_BITS-1:0] cand_value,
    output logic [IDX_BITS-1:0]   best_idx,
    output logic [VALUE_BITS-1:0] best_value,
    output logic                  best_any
);
    import kwm_pkg::*;

    logic                  any_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  take;

    // strict less-than on an ascending scan keeps the lowest index on ties
    assign take = ctrl.valid && ctrl.present &&
                  (!any_reg || ($signed(cand_value) < $signed(value_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg <= 1'b0;
        end else if (ctrl.clear) begin
            any_reg <= 1'b0;
        end else if (take) begin
            any_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            idx_reg   <= cand_idx;
            value_reg <= cand_value;
        end
    end

    assign best_idx   = idx_reg;
    assign best_value = value_reg;
    assign best_any   = any_reg;

endmodule

@@ rtl/k_way_sorted_merge.sv @@
// K-way sorted merge of up to LISTS ascending streams.
// Input requests carry one list's next element or, with s_axis_tuser low,
// mark that list exhausted. Once every list in use holds a head or is
// exhausted, the block returns the smallest head and its list index on the
// m_axis channel; the producer then sends that list's next element. When
// all lists are exhausted and no head remains, one result with m_axis_tlast
// high and zero data closes the merge and all list state is cleared.
// cfg_we writes lists_in_use (lists 0 .. n-1 take part; 0 acts as 1, values
// above LISTS act as LISTS); write it only while the block is idle.
// Heads live in a one-port-read memory; one shared comparator walks the n
// heads, one memory read per cycle; the registered read data feeds the
// comparator, and after the walk the result is loaded. The scan stops early,
// with no result, when a list still lacks a head. No new request is taken
// until the scan and the result load are done.
// The result sits in an output register: a stalled receiver holds it while
// the next request is taken and scanned; the block waits only to load a new
// result. Reset clears the head flags and sets lists_in_use to 16.
`include "k_way_sorted_merge_defines.svh"

module k_way_sorted_merge #(
    parameter int LISTS = 16,
    parameter int VALUE_BITS = 32,
    localparam int IDX_BITS = $clog2(LISTS),
    localparam int CNT_BITS = $clog2(LISTS + 1),
    localparam int DATA_BITS = ((VALUE_BITS + IDX_BITS + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [kwm_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [DATA_BITS-1:0]         s_axis_tdata,  // list_index, value
    input  logic                         s_axis_tuser,  // has_value
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [DATA_BITS-1:0]         m_axis_tdata,  // merged_value, source_list
    output logic                         m_axis_tlast
);
    import kwm_pkg::*;

    logic [CFG_BITS-1:0]   lists_reg;
    logic [CNT_BITS-1:0]   n_eff;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   ptr_reg, ptr_next;
    logic [IDX_BITS-1:0]   ptr_idx;
    logic                  pipe_valid_reg, pipe_valid_next;
    logic [IDX_BITS-1:0]   pipe_idx_reg;
    logic [LISTS-1:0]      present_reg, present_next;
    logic [LISTS-1:0]      exhaust_reg, exhaust_next;

    logic [VALUE_BITS-1:0] mem [LISTS];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  mem_we;

    logic [IDX_BITS-1:0]   in_idx;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_use;
    logic                  s_accept;
    logic                  missing;

    cmp_ctrl_t             cmp_ctrl;
    logic                  scan_clear;
    logic [IDX_BITS-1:0]   best_idx;
    logic [VALUE_BITS-1:0] best_value;
    logic                  best_any;

    logic                  out_load;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [IDX_BITS-1:0]   out_src_reg;
    logic                  out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lists_reg <= CFG_RESET;
        end else if (cfg_we) begin
            lists_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (lists_reg == '0) begin
            n_eff = CNT_BITS'(1);
        end else if (32'(lists_reg) > 32'(LISTS)) begin
            n_eff = CNT_BITS'(LISTS);
        end else begin
            n_eff = CNT_BITS'(lists_reg);
        end
    end

    assign in_idx   = s_axis_tdata[IDX_BITS-1:0];
    assign in_value = s_axis_tdata[IDX_BITS +: VALUE_BITS];
    assign in_use   = CNT_BITS'(in_idx) < n_eff;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign mem_we        = s_accept && in_use && s_axis_tuser;

    assign ptr_idx = ptr_reg[IDX_BITS-1:0];
    assign missing = !present_reg[ptr_idx] && !exhaust_reg[ptr_idx];

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        pipe_valid_next = 1'b0;
        present_next    = present_reg;
        exhaust_next    = exhaust_reg;
        scan_clear      = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_use) begin
                        if (s_axis_tuser) begin
                            present_next[in_idx] = 1'b1;
                            exhaust_next[in_idx] = 1'b0;
                        end else begin
                            exhaust_next[in_idx] = 1'b1;
                        end
                    end
                    ptr_next   = '0;
                    scan_clear = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (ptr_reg < n_eff) begin
                    if (missing) begin
                        state_next = ST_IDLE;
                    end else begin
                        pipe_valid_next = 1'b1;
                        ptr_next        = ptr_reg + CNT_BITS'(1);
                    end
                end else if (!pipe_valid_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (best_any) begin
                        present_next[best_idx] = 1'b0;
                    end else begin
                        present_next = '0;
                        exhaust_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            present_reg    <= '0;
            exhaust_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            pipe_valid_reg <= pipe_valid_next;
            present_reg    <= present_next;
            exhaust_reg    <= exhaust_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[in_idx] <= in_value;
        end
        rdata_reg    <= mem[ptr_idx];
        pipe_idx_reg <= ptr_idx;
    end

    assign cmp_ctrl.clear   = scan_clear;
    assign cmp_ctrl.valid   = pipe_valid_reg;
    assign cmp_ctrl.present = present_reg[pipe_idx_reg];

    kwm_min_track #(
        .IDX_BITS   (IDX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_min_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (cmp_ctrl),
        .cand_idx   (pipe_idx_reg),
        .cand_value (rdata_reg),
        .best_idx   (best_idx),
        .best_value (best_value),
        .best_any   (best_any)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= best_any ? best_value : '0;
            out_src_reg   <= best_any ? best_idx : '0;
            out_last_reg  <= !best_any;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'({out_src_reg, out_value_reg});
    assign m_axis_tlast  = out_last_reg;

    `KWM_ASSERT_CLK(a_accept_starts_scan, s_axis_tvalid && s_axis_tready |=> state_reg == ST_SCAN && ptr_reg == '0, "accepted request did not start a scan")
    `KWM_ASSERT_CLK(a_scan_bound, state_reg == ST_SCAN |-> ptr_reg <= n_eff, "scan pointer ran past the lists in use")
    `KWM_ASSERT_CLK(a_emit_drops_head, out_load && best_any |=> !present_reg[$past(best_idx)], "emitted head still marked present")
    `KWM_ASSERT_CLK(a_end_clears, out_load && !best_any |=> present_reg == '0 && exhaust_reg == '0, "end of merge left list state behind")
    `KWM_ASSERT_CLK(a_load_free, out_load |-> !out_valid_reg || m_axis_tready, "result loaded over a pending result")

endmodule
